[rtl/core/i2cm_pkg.sv]
package i2cm_pkg;

   // Width of the bus delay counter; the configured delay is cut to this width
   localparam int DELAY_WIDTH = 16;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;
   localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

   // Request kinds carried in req_tuser
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // Bus sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_RS_A = 4'd1,
      PH_RS_B = 4'd2,
      PH_ST_A = 4'd3,
      PH_ST_B = 4'd4,
      PH_WB_A = 4'd5,
      PH_WB_B = 4'd6,
      PH_GAP  = 4'd7,
      PH_RB_A = 4'd8,
      PH_RB_B = 4'd9,
      PH_SP_A = 4'd10,
      PH_SP_B = 4'd11,
      PH_SP_C = 4'd12,
      PH_SP_D = 4'd13,
      PH_SP_E = 4'd14,
      PH_SP_F = 4'd15
   } phase_type;

   // Options latched with a command
   typedef struct packed {
      logic start;
      logic nack;
      logic stop;
      logic read;
   } opts_type;

   // Sequencer state
   typedef struct packed {
      phase_type              phase;
      logic [3:0]             bit_count;
      logic [DELAY_WIDTH-1:0] tick_count;
      logic [7:0]             shift_reg;
      logic                   bus_started;
      logic                   scl_level;
      logic                   sda_level;
      opts_type               opts;
      logic                   ack_latch;
      logic [7:0]             last_read;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:       PH_IDLE,
      bit_count:   4'd0,
      tick_count:  '0,
      shift_reg:   8'd0,
      bus_started: 1'b0,
      scl_level:   1'b1,
      sda_level:   1'b1,
      opts:        '0,
      ack_latch:   1'b0,
      last_read:   8'd0
   };

   // One input item, unpacked
   typedef struct packed {
      logic [1:0] req_type;
      logic       with_start;
      logic       with_stop;
      logic [7:0] write_data;
      logic       master_nack;
      logic       sda_in;
   } cmd_type;

   // One result item; last member lands in the lowest bits
   typedef struct packed {
      logic       rejected;
      logic [7:0] read_data;
      logic       slave_nack;
      logic       done_res;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } result_type;

endpackage

[rtl/core/i2c_master_byte_engine_core.sv]
// I2C master byte engine, standard-mode bit-bang sequencer.
// Each item on the req_ channel is one timer tick. req_tuser says whether the tick
// carries nothing, a write byte or a read byte command; req_tdata carries the
// start/stop options, the byte to send, the master ack bit and the sampled SDA.
// Every accepted item yields exactly one rsp_ item: SCL and SDA levels after the
// tick, busy, done, the slave ack bit of the last write, the last read byte and a
// flag for a command ignored because a transfer was running.
// csr_ writes the half period in ticks; it is always ready. It must be written only
// while the bus is idle; the block itself does not enforce this.
// The result of an item is registered and valid on the cycle after it is accepted.
// Throughput: one item per cycle unless a waiting result is not taken; the tick step
// is a single combinational pass between the state registers and the result register.
// Stall: while a result waits with rsp_tready low, req_tready is low; once the
// result is taken a new item is accepted in that same cycle.
// Reset: sequencer idle, SCL and SDA released, half period 250 ticks, no result.
module i2c_master_byte_engine_core (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: with_start, with_stop, write_data[7:0], master_nack, sda_in, 4'b0
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // req_tuser: req_type[1:0]
   input  logic [1:0]  req_tuser,
   // rsp_tdata: scl_out, sda_out, busy_res, done_res, slave_nack, read_data[7:0],
   //            rejected, 2'b0
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic                             req_fire;
   logic [15:0]                      half_period_ff;
   logic [i2cm_pkg::DELAY_WIDTH-1:0] delay_ticks;
   logic [i2cm_pkg::DELAY_WIDTH-1:0] delay_m1;
   i2cm_pkg::state_type              state_ff;
   i2cm_pkg::state_type              state_in;
   i2cm_pkg::cmd_type                cmd;
   i2cm_pkg::result_type             result_in;
   logic                             step_done;
   logic                             step_rejected;
   logic                             rsp_valid_ff;
   logic [15:0]                      rsp_data_ff;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // Delay unit: zero counts as one tick
   assign delay_ticks = i2cm_pkg::DELAY_WIDTH'(half_period_ff);
   assign delay_m1    = (delay_ticks == '0) ? '0 : delay_ticks - 1'b1;

   // Unpack the input item
   assign cmd.req_type    = req_tuser;
   assign cmd.with_start  = req_tdata[0];
   assign cmd.with_stop   = req_tdata[1];
   assign cmd.write_data  = req_tdata[9:2];
   assign cmd.master_nack = req_tdata[10];
   assign cmd.sda_in      = req_tdata[11];

   i2cm_step u_step (
      .cur      (state_ff),
      .cmd      (cmd),
      .delay_m1 (delay_m1),
      .nxt      (state_in),
      .done     (step_done),
      .rejected (step_rejected)
   );

   // Result fields
   assign result_in.scl_out    = state_in.scl_level;
   assign result_in.sda_out    = state_in.sda_level;
   assign result_in.busy_res   = (state_in.phase != i2cm_pkg::PH_IDLE);
   assign result_in.done_res   = step_done;
   assign result_in.slave_nack = state_in.ack_latch;
   assign result_in.read_data  = state_in.last_read;
   assign result_in.rejected   = step_rejected;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset)
         half_period_ff <= i2cm_pkg::HALF_PERIOD_RESET;
      else if (csr_valid && csr_ready)
         half_period_ff <= csr_data;
   end

   // Sequencer state, advanced once per accepted item
   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= i2cm_pkg::STATE_RESET;
      else if (req_fire)
         state_ff <= state_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (req_fire)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_fire)
         rsp_data_ff <= {2'b00, result_in};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("accepted item produced no result");

   a_reject_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13] |-> rsp_tdata[2])
      else $error("command rejected while sequencer idle");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.bit_count <= i2cm_pkg::BITS_PER_BYTE)
      else $error("bit counter out of range");

endmodule

[rtl/core/i2cm_step.sv]
// One tick of the bus sequencer: delay countdown, phase advance and command intake
module i2cm_step (
   input  i2cm_pkg::state_type                    cur,
   input  i2cm_pkg::cmd_type                      cmd,
   input  logic [i2cm_pkg::DELAY_WIDTH-1:0]       delay_m1,
   output i2cm_pkg::state_type                    nxt,
   output logic                                   done,
   output logic                                   rejected
);

   i2cm_pkg::state_type s;
   logic                do_finish;
   logic                is_cmd;
   logic                is_read;

   // Enter a phase: reload the delay and apply the pin change of that phase
   function automatic i2cm_pkg::state_type enter_phase(
      input i2cm_pkg::state_type               st,
      input i2cm_pkg::phase_type               p,
      input logic [i2cm_pkg::DELAY_WIDTH-1:0]  dm1
   );
      i2cm_pkg::state_type r;
      r            = st;
      r.phase      = p;
      r.tick_count = dm1;
      unique case (p)
         i2cm_pkg::PH_RS_A: r.sda_level = 1'b1;
         i2cm_pkg::PH_RS_B: r.scl_level = 1'b1;
         i2cm_pkg::PH_ST_A: r.sda_level = 1'b0;
         i2cm_pkg::PH_WB_A: begin
            if (r.bit_count < i2cm_pkg::BITS_PER_BYTE)
               r.sda_level = r.shift_reg[7];
            else
               r.sda_level = r.opts.nack;
         end
         i2cm_pkg::PH_WB_B: r.scl_level = 1'b1;
         i2cm_pkg::PH_RB_A: r.sda_level = 1'b1;
         i2cm_pkg::PH_RB_B: r.scl_level = 1'b1;
         i2cm_pkg::PH_SP_A: r.sda_level = 1'b0;
         i2cm_pkg::PH_SP_C: r.scl_level = 1'b1;
         i2cm_pkg::PH_SP_E: r.sda_level = 1'b1;
         default: ;
      endcase
      return r;
   endfunction

   assign is_read = (cmd.req_type == i2cm_pkg::REQ_READ);
   assign is_cmd  = (cmd.req_type == i2cm_pkg::REQ_WRITE) || is_read;

   always_comb begin
      s         = cur;
      done      = 1'b0;
      rejected  = 1'b0;
      do_finish = 1'b0;

      // Count down the current segment, advance when it runs out
      if (s.phase != i2cm_pkg::PH_IDLE) begin
         if (s.tick_count != '0) begin
            s.tick_count = s.tick_count - 1'b1;
         end else begin
            unique case (s.phase)
               i2cm_pkg::PH_RS_A: s = enter_phase(s, i2cm_pkg::PH_RS_B, delay_m1);
               i2cm_pkg::PH_RS_B: s = enter_phase(s, i2cm_pkg::PH_ST_A, delay_m1);
               i2cm_pkg::PH_ST_A: s = enter_phase(s, i2cm_pkg::PH_ST_B, delay_m1);
               i2cm_pkg::PH_ST_B: begin
                  s.scl_level   = 1'b0;
                  s.bus_started = 1'b1;
                  s = enter_phase(s, s.opts.read ? i2cm_pkg::PH_RB_A : i2cm_pkg::PH_WB_A,
                                  delay_m1);
               end
               i2cm_pkg::PH_WB_A: s = enter_phase(s, i2cm_pkg::PH_WB_B, delay_m1);
               i2cm_pkg::PH_WB_B: begin
                  s.scl_level = 1'b0;
                  if (s.bit_count < i2cm_pkg::BITS_PER_BYTE) begin
                     s.shift_reg = {s.shift_reg[6:0], 1'b0};
                     s.bit_count = s.bit_count + 4'd1;
                     s = enter_phase(s, (s.bit_count < i2cm_pkg::BITS_PER_BYTE) ?
                                     i2cm_pkg::PH_WB_A : i2cm_pkg::PH_GAP, delay_m1);
                  end else begin
                     do_finish = 1'b1;
                  end
               end
               i2cm_pkg::PH_GAP:  s = enter_phase(s, i2cm_pkg::PH_RB_A, delay_m1);
               i2cm_pkg::PH_RB_A: s = enter_phase(s, i2cm_pkg::PH_RB_B, delay_m1);
               i2cm_pkg::PH_RB_B: begin
                  s.scl_level = 1'b0;
                  if (s.bit_count < i2cm_pkg::BITS_PER_BYTE) begin
                     s.shift_reg = {s.shift_reg[6:0], cmd.sda_in};
                     s.bit_count = s.bit_count + 4'd1;
                     if (s.bit_count < i2cm_pkg::BITS_PER_BYTE) begin
                        s = enter_phase(s, i2cm_pkg::PH_RB_A, delay_m1);
                     end else begin
                        // byte complete, master ack bit goes out next
                        s.last_read = s.shift_reg;
                        s = enter_phase(s, i2cm_pkg::PH_WB_A, delay_m1);
                     end
                  end else begin
                     s.ack_latch = cmd.sda_in;
                     do_finish   = 1'b1;
                  end
               end
               i2cm_pkg::PH_SP_A: s = enter_phase(s, i2cm_pkg::PH_SP_B, delay_m1);
               i2cm_pkg::PH_SP_B: s = enter_phase(s, i2cm_pkg::PH_SP_C, delay_m1);
               i2cm_pkg::PH_SP_C: s = enter_phase(s, i2cm_pkg::PH_SP_D, delay_m1);
               i2cm_pkg::PH_SP_D: s = enter_phase(s, i2cm_pkg::PH_SP_E, delay_m1);
               i2cm_pkg::PH_SP_E: s = enter_phase(s, i2cm_pkg::PH_SP_F, delay_m1);
               i2cm_pkg::PH_SP_F: begin
                  s.bus_started = 1'b0;
                  s.phase       = i2cm_pkg::PH_IDLE;
                  done          = 1'b1;
               end
               default: ;
            endcase
         end
      end

      // End of byte: stop sequence or back to idle
      if (do_finish) begin
         if (s.opts.stop) begin
            s = enter_phase(s, i2cm_pkg::PH_SP_A, delay_m1);
         end else begin
            s.phase = i2cm_pkg::PH_IDLE;
            done    = 1'b1;
         end
      end

      // Command intake, also on the completion tick
      if (is_cmd) begin
         if (s.phase == i2cm_pkg::PH_IDLE) begin
            s.opts.read  = is_read;
            s.opts.stop  = cmd.with_stop;
            s.opts.nack  = cmd.master_nack;
            s.opts.start = cmd.with_start;
            s.shift_reg  = is_read ? 8'd0 : cmd.write_data;
            s.bit_count  = 4'd0;
            if (cmd.with_start)
               s = enter_phase(s, s.bus_started ? i2cm_pkg::PH_RS_A : i2cm_pkg::PH_ST_A,
                               delay_m1);
            else
               s = enter_phase(s, is_read ? i2cm_pkg::PH_RB_A : i2cm_pkg::PH_WB_A,
                               delay_m1);
         end else begin
            rejected = 1'b1;
         end
      end

      nxt = s;
   end

endmodule

[tb/tb_i2c_master_byte_engine_core.sv]
`timescale 1ns / 100ps

module tb_i2c_master_byte_engine_core;

   // Request kind three: behaves as a plain tick
   localparam logic [1:0] REQ_SPARE = 2'd3;
   localparam int QUIET_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 1100;

   // Software copy of the sequencer
   typedef struct packed {
      i2cm_pkg::phase_type              phase;
      logic [3:0]                       bits;
      logic [i2cm_pkg::DELAY_WIDTH-1:0] ticks;
      logic [7:0]                       shifter;
      logic                             started;
      logic                             scl;
      logic                             sda;
      i2cm_pkg::opts_type               opts;
      logic                             ack;
      logic [7:0]                       last_byte;
      logic                             done;
   } bus_model_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   // Pending ticks and the bus responses they are due to produce
   i2cm_pkg::cmd_type     tick_queue[$];
   i2cm_pkg::result_type  rsp_due[$];

   bus_model_type gen_bus;          // tracks the stimulus stream as it is built
   logic [15:0]   gen_half = i2cm_pkg::HALF_PERIOD_RESET;
   bus_model_type chk_bus;          // advanced on every accepted tick
   logic [15:0]   chk_half = i2cm_pkg::HALF_PERIOD_RESET;

   int          mismatches = 0;
   int          made = 0;
   int          quiet_cycles = 0;
   bit          tx_idle_on = 1'b0;
   bit          rx_idle_on = 1'b0;
   bit          tx_busy = 1'b0;
   int unsigned tx_wait = 0;
   int unsigned rx_wait = 0;
   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   i2cm_pkg::cmd_type    nxt_cmd;
   i2cm_pkg::cmd_type    seen_cmd;
   i2cm_pkg::result_type want_rsp;

   i2c_master_byte_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Sequencer prediction
   // ---------------------------------------------------------------
   function automatic bus_model_type bus_idle();
      bus_model_type m;
      m.phase     = i2cm_pkg::PH_IDLE;
      m.bits      = 4'd0;
      m.ticks     = '0;
      m.shifter   = 8'd0;
      m.started   = 1'b0;
      m.scl       = 1'b1;
      m.sda       = 1'b1;
      m.opts      = '0;
      m.ack       = 1'b0;
      m.last_byte = 8'd0;
      m.done      = 1'b0;
      return m;
   endfunction

   // Start a bus segment; a zero delay still lasts one tick
   task automatic enter_seg(inout bus_model_type m, input i2cm_pkg::phase_type p,
                            input logic [15:0] half);
      logic [i2cm_pkg::DELAY_WIDTH-1:0] dly;
      dly     = i2cm_pkg::DELAY_WIDTH'(half);
      m.phase = p;
      m.ticks = (dly == '0) ? '0 : dly - 1'b1;
      case (p)
         i2cm_pkg::PH_RS_A, i2cm_pkg::PH_RB_A, i2cm_pkg::PH_SP_E: m.sda = 1'b1;
         i2cm_pkg::PH_RS_B, i2cm_pkg::PH_WB_B, i2cm_pkg::PH_RB_B, i2cm_pkg::PH_SP_C:
            m.scl = 1'b1;
         i2cm_pkg::PH_ST_A, i2cm_pkg::PH_SP_A: m.sda = 1'b0;
         i2cm_pkg::PH_WB_A:
            m.sda = (m.bits < i2cm_pkg::BITS_PER_BYTE) ? m.shifter[7] : m.opts.nack;
         default: ;
      endcase
   endtask

   task automatic byte_end(inout bus_model_type m, input logic [15:0] half);
      if (m.opts.stop) begin
         enter_seg(m, i2cm_pkg::PH_SP_A, half);
      end else begin
         m.phase = i2cm_pkg::PH_IDLE;
         m.done  = 1'b1;
      end
   endtask

   // Segment delay ran out: move to the next segment
   task automatic segment_end(inout bus_model_type m, input logic sda_in,
                              input logic [15:0] half);
      case (m.phase)
         i2cm_pkg::PH_ST_B: begin
            m.scl     = 1'b0;
            m.started = 1'b1;
            enter_seg(m, m.opts.read ? i2cm_pkg::PH_RB_A : i2cm_pkg::PH_WB_A, half);
         end
         i2cm_pkg::PH_WB_B: begin
            m.scl = 1'b0;
            if (m.bits < i2cm_pkg::BITS_PER_BYTE) begin
               m.shifter = {m.shifter[6:0], 1'b0};
               m.bits    = m.bits + 4'd1;
               enter_seg(m, (m.bits < i2cm_pkg::BITS_PER_BYTE) ?
                         i2cm_pkg::PH_WB_A : i2cm_pkg::PH_GAP, half);
            end else begin
               byte_end(m, half);
            end
         end
         i2cm_pkg::PH_GAP: enter_seg(m, i2cm_pkg::PH_RB_A, half);
         i2cm_pkg::PH_RB_B: begin
            m.scl = 1'b0;
            if (m.bits < i2cm_pkg::BITS_PER_BYTE) begin
               m.shifter = {m.shifter[6:0], sda_in};
               m.bits    = m.bits + 4'd1;
               if (m.bits < i2cm_pkg::BITS_PER_BYTE) begin
                  enter_seg(m, i2cm_pkg::PH_RB_A, half);
               end else begin
                  m.last_byte = m.shifter;
                  enter_seg(m, i2cm_pkg::PH_WB_A, half);
               end
            end else begin
               m.ack = sda_in;
               byte_end(m, half);
            end
         end
         i2cm_pkg::PH_SP_F: begin
            m.started = 1'b0;
            m.phase   = i2cm_pkg::PH_IDLE;
            m.done    = 1'b1;
         end
         default: enter_seg(m, i2cm_pkg::phase_type'(m.phase + 4'd1), half);
      endcase
   endtask

   // One timer tick: advance the bus, then take or reject a command
   task automatic bus_tick(inout bus_model_type m, input i2cm_pkg::cmd_type c,
                           input logic [15:0] half, output i2cm_pkg::result_type r);
      logic is_cmd;
      logic refused;
      is_cmd  = (c.req_type == i2cm_pkg::REQ_WRITE) || (c.req_type == i2cm_pkg::REQ_READ);
      refused = 1'b0;
      m.done  = 1'b0;
      if (m.phase != i2cm_pkg::PH_IDLE) begin
         if (m.ticks != '0) m.ticks = m.ticks - 1'b1;
         else segment_end(m, c.sda_in, half);
      end
      if (is_cmd) begin
         if (m.phase == i2cm_pkg::PH_IDLE) begin
            m.opts.read  = (c.req_type == i2cm_pkg::REQ_READ);
            m.opts.stop  = c.with_stop;
            m.opts.nack  = c.master_nack;
            m.opts.start = c.with_start;
            m.shifter    = m.opts.read ? 8'd0 : c.write_data;
            m.bits       = 4'd0;
            if (c.with_start)
               enter_seg(m, m.started ? i2cm_pkg::PH_RS_A : i2cm_pkg::PH_ST_A, half);
            else
               enter_seg(m, m.opts.read ? i2cm_pkg::PH_RB_A : i2cm_pkg::PH_WB_A, half);
         end else begin
            refused = 1'b1;
         end
      end
      r.scl_out    = m.scl;
      r.sda_out    = m.sda;
      r.busy_res   = (m.phase != i2cm_pkg::PH_IDLE);
      r.done_res   = m.done;
      r.slave_nack = m.ack;
      r.read_data  = m.last_byte;
      r.rejected   = refused;
   endtask

   // ---------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------
   function automatic int unsigned idle_draw(bit on);
      return on ? $urandom_range(0, 19) : 32'd0;
   endfunction

   function automatic i2cm_pkg::cmd_type make_cmd(logic [1:0] kind, logic start, logic stop,
                                                  logic [7:0] data, logic nack, logic sda);
      i2cm_pkg::cmd_type c;
      c.req_type    = kind;
      c.with_start  = start;
      c.with_stop   = stop;
      c.write_data  = data;
      c.master_nack = nack;
      c.sda_in      = sda;
      return c;
   endfunction

   // Tick with random content; one in noise is a command (0: never)
   function automatic i2cm_pkg::cmd_type filler_item(int unsigned noise);
      i2cm_pkg::cmd_type f;
      f = make_cmd(i2cm_pkg::REQ_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      if (noise != 0 && $urandom_range(1, noise) == 1)
         f.req_type = $urandom_range(0, 1) ? i2cm_pkg::REQ_WRITE : i2cm_pkg::REQ_READ;
      else if ($urandom_range(0, 9) == 0)
         f.req_type = REQ_SPARE;
      return f;
   endfunction

   function automatic i2cm_pkg::cmd_type rand_cmd();
      return make_cmd($urandom_range(0, 1) ? i2cm_pkg::REQ_WRITE : i2cm_pkg::REQ_READ,
                      $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
   endfunction

   task automatic queue_item(input i2cm_pkg::cmd_type c);
      i2cm_pkg::result_type scratch;
      tick_queue.push_back(c);
      bus_tick(gen_bus, c, gen_half, scratch);
      made++;
   endtask

   // Place a command: on the completion tick when chained, else once the bus is idle
   task automatic issue(input i2cm_pkg::cmd_type c, input bit chain,
                        input int unsigned noise);
      i2cm_pkg::cmd_type    f;
      bus_model_type        peek;
      i2cm_pkg::result_type r;
      bit                   placed;
      placed = 1'b0;
      while (gen_bus.phase != i2cm_pkg::PH_IDLE && !placed) begin
         f    = filler_item(noise);
         peek = gen_bus;
         bus_tick(peek, f, gen_half, r);
         if (chain && r.done_res) placed = 1'b1;
         else queue_item(f);
      end
      queue_item(c);
   endtask

   task automatic settle();
      while (gen_bus.phase != i2cm_pkg::PH_IDLE) queue_item(filler_item(0));
   endtask

   // Sender holds off until every queued tick has answered
   task automatic wait_drained();
      do @(negedge clock);
      while (tick_queue.size() != 0 || rsp_due.size() != 0 || tx_busy);
   endtask

   task automatic write_half(input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      chk_half = value;
      gen_half = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Driver: request channel, changes on the falling edge
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (tx_wait > 0) begin
            tx_wait = tx_wait - 1;
            tx_busy = 1'b0;
            req_tvalid <= 1'b0;
         end else if (tick_queue.size() > 0) begin
            nxt_cmd = tick_queue.pop_front();
            tx_busy = 1'b1;
            req_tuser  <= nxt_cmd.req_type;
            req_tdata  <= {4'b0, nxt_cmd.sda_in, nxt_cmd.master_nack, nxt_cmd.write_data,
                           nxt_cmd.with_stop, nxt_cmd.with_start};
            req_tvalid <= 1'b1;
            tx_wait = idle_draw(tx_idle_on);
         end else begin
            tx_busy = 1'b0;
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) rx_wait = idle_draw(rx_idle_on);
         if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: checks responses, predicts accepted ticks
   // ---------------------------------------------------------------
   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_due.size() == 0) begin
               $error("response with no tick outstanding: %h", rsp_tdata);
               mismatches++;
            end else begin
               want_rsp = rsp_due.pop_front();
               check_field("scl_out", 8'(want_rsp.scl_out), 8'(rsp_tdata[0]));
               check_field("sda_out", 8'(want_rsp.sda_out), 8'(rsp_tdata[1]));
               check_field("busy_res", 8'(want_rsp.busy_res), 8'(rsp_tdata[2]));
               check_field("done_res", 8'(want_rsp.done_res), 8'(rsp_tdata[3]));
               check_field("slave_nack", 8'(want_rsp.slave_nack), 8'(rsp_tdata[4]));
               check_field("read_data", want_rsp.read_data, rsp_tdata[12:5]);
               check_field("rejected", 8'(want_rsp.rejected), 8'(rsp_tdata[13]));
            end
         end
         if (req_tvalid && req_tready) begin
            seen_cmd = make_cmd(req_tuser, req_tdata[0], req_tdata[1], req_tdata[9:2],
                                req_tdata[10], req_tdata[11]);
            bus_tick(chk_bus, seen_cmd, chk_half, want_rsp);
            rsp_due.push_back(want_rsp);
         end
      end
   end

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      int          random_start;
      int          phase_start;
      int unsigned pick;
      bit          chain;
      logic [15:0] half;

      gen_bus = bus_idle();
      chk_bus = bus_idle();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Idle bus at the reset delay: plain ticks and the spare kind
      queue_item(make_cmd(i2cm_pkg::REQ_TICK, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1));
      queue_item(make_cmd(REQ_SPARE, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1));
      queue_item(make_cmd(i2cm_pkg::REQ_TICK, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
      wait_drained();

      // Shortest delay: byte without start, then chained start, restart, read NACK + stop
      write_half(16'd1);
      issue(make_cmd(i2cm_pkg::REQ_WRITE, 1'b0, 1'b0, 8'hA5, 1'b0, 1'b0), 1'b0, 0);
      issue(make_cmd(i2cm_pkg::REQ_WRITE, 1'b1, 1'b0, 8'hFF, 1'b1, 1'b1), 1'b1, 5);
      issue(make_cmd(i2cm_pkg::REQ_READ, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1), 1'b1, 5);
      issue(make_cmd(i2cm_pkg::REQ_READ, 1'b0, 1'b1, 8'h3C, 1'b1, 1'b0), 1'b1, 5);
      issue(make_cmd(i2cm_pkg::REQ_WRITE, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0), 1'b0, 5);
      issue(make_cmd(i2cm_pkg::REQ_WRITE, 1'b1, 1'b1, 8'h80, 1'b1, 1'b1), 1'b1, 5);
      settle();
      wait_drained();

      // Zero delay acts as one tick
      write_half(16'd0);
      issue(make_cmd(i2cm_pkg::REQ_READ, 1'b1, 1'b1, 8'h5A, 1'b1, 1'b1), 1'b0, 0);
      settle();

      // Random transfers, mostly short delays
      random_start = made;
      while (made - random_start < RANDOM_ITEMS) begin
         wait_drained();
         pick = $urandom_range(0, 7);
         if (pick == 0) half = 16'd0;
         else if (pick <= 3) half = 16'd1;
         else if (pick <= 5) half = 16'd2;
         else half = 16'($urandom_range(3, 6));
         write_half(half);
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         phase_start = made;
         while (made - phase_start < 250) begin
            chain = ($urandom_range(0, 2) == 0);
            if (!chain) repeat ($urandom_range(0, 3)) queue_item(filler_item(0));
            issue(rand_cmd(), chain, 40);
         end
         settle();
      end

      // One transfer at a longer delay
      wait_drained();
      write_half(16'($urandom_range(10, 16)));
      issue(rand_cmd(), 1'b0, 20);
      settle();

      // Largest delay: bus stays in its first segment, commands are refused
      wait_drained();
      write_half(16'hFFFF);
      issue(make_cmd(i2cm_pkg::REQ_WRITE, 1'b1, 1'b1, 8'($urandom_range(0, 255)), 1'b0, 1'b0),
            1'b0, 0);
      repeat (40) queue_item(filler_item(4));

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
